// ===== design/sed_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sed_pkg: shared types, codes and helpers of the string escape decoder
// Byte codes, phase and result codes, result, slot and state structs, hex and
// escape lookup functions, and the count clamp.
// ----------------------------------------------------------------------------
package sed_pkg;

    localparam int MAX_LEN     = 4096;
    localparam int CNT_W       = $clog2(MAX_LEN + 1);
    localparam int OUT_CNT_W   = 13;
    localparam int OUT_CNT_MAX = (1 << OUT_CNT_W) - 1;

    // raw characters that steer the decoder
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_X      = 8'h78;

    // decode phases
    localparam logic [2:0] PH_NORMAL = 3'd0;
    localparam logic [2:0] PH_ESC    = 3'd1;
    localparam logic [2:0] PH_HEX1   = 3'd2;
    localparam logic [2:0] PH_HEX2   = 3'd3;
    localparam logic [2:0] PH_DROP   = 3'd4;

    // result kinds
    localparam logic [1:0] K_DATA   = 2'd0;
    localparam logic [1:0] K_DONE   = 2'd1;
    localparam logic [1:0] K_TRUNC  = 2'd2;
    localparam logic [1:0] K_BADHEX = 2'd3;

    typedef struct packed {
        logic [7:0]           out_byte;
        logic [1:0]           kind;
        logic [OUT_CNT_W-1:0] out_count;
        logic                 end_of_run;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_slot;

    typedef struct packed {
        logic [2:0]       phase;
        logic [3:0]       nibble;
        logic [CNT_W-1:0] count;
    } t_state;

    // {is_hex, value}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'h00;
            if (c inside {[8'h30:8'h39]}) begin
                d = c - 8'h30;
                return {1'b1, d[3:0]};
            end else if (c inside {[8'h61:8'h66]}) begin
                d = c - 8'h57;
                return {1'b1, d[3:0]};
            end else if (c inside {[8'h41:8'h46]}) begin
                d = c - 8'h37;
                return {1'b1, d[3:0]};
            end
            return 5'b0_0000;
        end
    endfunction

    function automatic logic [7:0] escape_map(input logic [7:0] c);
        case (c)
            8'h30:   return 8'h00;
            8'h61:   return 8'h07;
            8'h62:   return 8'h08;
            8'h65:   return 8'h1B;
            8'h66:   return 8'h0C;
            8'h6E:   return 8'h0A;
            8'h72:   return 8'h0D;
            8'h74:   return 8'h09;
            8'h76:   return 8'h0B;
            default: return c;
        endcase
    endfunction

    function automatic logic [OUT_CNT_W-1:0] count_field(input logic [CNT_W-1:0] c);
        if (c > CNT_W'(OUT_CNT_MAX)) begin
            return OUT_CNT_W'(OUT_CNT_MAX);
        end
        return OUT_CNT_W'(c);
    endfunction

endpackage
`default_nettype wire

// ===== design/sed_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sed_in_if: raw byte channel
// Valid/ready channel carrying one string body byte and its end flag.
// ----------------------------------------------------------------------------
interface sed_in_if import sed_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

// ===== design/sed_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sed_out_if: decoded result channel
// Valid/ready channel carrying decoded bytes and end-of-string reports.
// ----------------------------------------------------------------------------
interface sed_out_if import sed_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [7:0]           out_byte;
    logic [1:0]           kind;
    logic [OUT_CNT_W-1:0] out_count;
    logic                 end_of_run;

    modport source (output valid, output out_byte, output kind, output out_count,
                    output end_of_run, input ready);
    modport sink   (input valid, input out_byte, input kind, input out_count,
                    input end_of_run, output ready);
endinterface
`default_nettype wire

// ===== design/string_escape_decoder.sv =====
`default_nettype none
// A byte is held in the input register, then decoded into the result register that drives the output.
// One byte per cycle while the output side has room; a byte that yields a data
// result and the end report (data byte that is the last) holds the output for
// both results, since there is a single output port.
// Reset: synchronous, active low; phase returns to normal text, nibble and
// count to zero, and both the input and output stages empty.
// ----------------------------------------------------------------------------
// string_escape_decoder: backslash escape decoder for string literal bodies
// Input register, one-pass decode, and a result register with a one-deep
// overflow slot for the end report that follows a final data byte.
// ----------------------------------------------------------------------------
module string_escape_decoder import sed_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sed_in_if.sink      i_in,
    sed_out_if.source   o_out
);

    // input stage
    logic       r_a_valid;
    logic [7:0] r_a_byte;
    logic       r_a_last;

    // decode state
    t_state r_state;
    t_state n_state;

    // result register and overflow slot
    logic    r_o_valid;
    t_result r_o;
    logic    r_o2_valid;
    t_result r_o2;

    t_slot res0;
    t_slot res1;

    logic room;    // output side can absorb both results of one byte
    logic a_take;  // input stage byte is decoded this cycle
    logic pop;     // result transaction on the output

    sed_step u_step (
        .i_state (r_state),
        .i_byte  (r_a_byte),
        .i_last  (r_a_last),
        .o_state (n_state),
        .o_res0  (res0),
        .o_res1  (res1)
    );

    assign pop    = r_o_valid && o_out.ready;
    // overflow slot must be empty, result register empty or leaving
    assign room   = !r_o2_valid && (!r_o_valid || o_out.ready);
    assign a_take = r_a_valid && room;

    // input register takes a byte when empty or when its byte is decoded this cycle
    assign i_in.ready = !r_a_valid || a_take;

    assign o_out.valid      = r_o_valid;
    assign o_out.out_byte   = r_o.out_byte;
    assign o_out.kind       = r_o.kind;
    assign o_out.out_count  = r_o.out_count;
    assign o_out.end_of_run = r_o.end_of_run;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid  <= 1'b0;
            r_o_valid  <= 1'b0;
            r_o2_valid <= 1'b0;
            r_state    <= '{phase: PH_NORMAL, nibble: 4'h0, count: '0};
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_a_valid <= 1'b1;
            end else if (a_take) begin
                r_a_valid <= 1'b0;
            end

            if (a_take) begin
                r_state    <= n_state;
                r_o_valid  <= res0.valid;
                r_o2_valid <= res1.valid;
            end else if (pop) begin
                // end report moves up behind its data byte
                r_o_valid  <= r_o2_valid;
                r_o2_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_a_byte <= i_in.data_byte;
            r_a_last <= i_in.last_byte;
        end
        if (a_take) begin
            r_o  <= res0.res;
            r_o2 <= res1.res;
        end else if (pop) begin
            r_o <= r_o2;
        end
    end

    // overflow slot is only ever filled behind a waiting result
    a_o2_behind_o: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o2_valid |-> r_o_valid)
        else $error("overflow slot holds a result with the result register empty");

    // overflow slot only carries the end report of a finished string
    a_o2_is_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o2_valid |-> (r_o2.kind == K_DONE && r_o2.end_of_run))
        else $error("overflow slot holds something other than a done report");

    // the last byte of a string always leaves the decoder clean
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_take && r_a_last) |=>
            (r_state.phase == PH_NORMAL && r_state.count == '0 && r_state.nibble == 4'h0))
        else $error("decode state not cleared after string end");

    // count never runs past the saturation limit
    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.count <= CNT_W'(MAX_LEN))
        else $error("byte count beyond saturation limit");

    // a result that has no end flag is always a data byte
    a_mid_is_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_o.end_of_run) |-> (r_o.kind == K_DATA))
        else $error("non-final result with a report kind");

endmodule
`default_nettype wire

// ===== design/sed_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sed_step: per-byte decode logic
// Next phase, nibble and count, and up to two results for one raw byte.
// ----------------------------------------------------------------------------
module sed_step import sed_pkg::*; (
    input  t_state     i_state,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_state     o_state,
    output t_slot      o_res0,
    output t_slot      o_res1
);

    logic [4:0]       hex;
    logic [CNT_W-1:0] cnt_inc;
    logic [7:0]       emit_byte;
    logic             do_emit;
    logic             do_finish;
    logic [1:0]       fin_kind;

    always_comb begin
        hex       = hex_value(i_byte);
        cnt_inc   = (i_state.count < CNT_W'(MAX_LEN)) ? i_state.count + 1'b1
                                                       : i_state.count;
        o_state   = i_state;
        emit_byte = i_byte;
        do_emit   = 1'b0;
        do_finish = 1'b0;
        fin_kind  = K_TRUNC;

        case (i_state.phase)
            PH_ESC: begin
                if (i_byte == CH_X) begin
                    o_state.phase = PH_HEX1;
                    do_finish     = i_last;
                end else begin
                    emit_byte = escape_map(i_byte);
                    do_emit   = 1'b1;
                end
            end
            PH_HEX1: begin
                if (!hex[4]) begin
                    o_state.phase = PH_DROP;
                    fin_kind      = K_BADHEX;
                end else begin
                    o_state.nibble = hex[3:0];
                    o_state.phase  = PH_HEX2;
                end
                do_finish = i_last;
            end
            PH_HEX2: begin
                if (!hex[4]) begin
                    o_state.phase = PH_DROP;
                    fin_kind      = K_BADHEX;
                    do_finish     = i_last;
                end else begin
                    emit_byte      = {i_state.nibble, hex[3:0]};
                    o_state.nibble = 4'h0;
                    do_emit        = 1'b1;
                end
            end
            PH_DROP: begin
                fin_kind  = K_BADHEX;
                do_finish = i_last;
            end
            default: begin
                if (i_byte == CH_BSLASH) begin
                    o_state.phase = PH_ESC;
                    do_finish     = i_last;
                end else begin
                    do_emit = 1'b1;
                end
            end
        endcase

        o_res0 = '0;
        o_res1 = '0;
        if (do_emit) begin
            o_state.phase  = PH_NORMAL;
            o_state.count  = cnt_inc;
            o_res0.valid   = 1'b1;
            o_res0.res     = '{out_byte: emit_byte, kind: K_DATA,
                               out_count: count_field(cnt_inc), end_of_run: 1'b0};
            if (i_last) begin
                o_res1.valid = 1'b1;
                o_res1.res   = '{out_byte: 8'h00, kind: K_DONE,
                                 out_count: count_field(cnt_inc), end_of_run: 1'b1};
                o_state      = '{phase: PH_NORMAL, nibble: 4'h0, count: '0};
            end
        end else if (do_finish) begin
            o_res0.valid = 1'b1;
            o_res0.res   = '{out_byte: 8'h00, kind: fin_kind,
                             out_count: count_field(i_state.count), end_of_run: 1'b1};
            o_state      = '{phase: PH_NORMAL, nibble: 4'h0, count: '0};
        end
    end

endmodule
`default_nettype wire
